// ----- hdl/fq_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; imported by fixed_point_q24_8_alu.
`timescale 1ns / 1ps

package fq_pkg;

    localparam int DATA_BITS = 32;
    localparam int WORD_W    = 32;
    localparam int SAT_BITS  = (DATA_BITS < WORD_W) ? DATA_BITS : WORD_W;
    localparam int WIDE_W    = 72;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t SAT_HI = (wide_t'(1) <<< (SAT_BITS - 1)) - wide_t'(1);
    localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } op_t;

    typedef struct packed {
        word_t value;
        logic  ovf;
    } sat_t;

    // word travelling alongside the divider
    typedef struct packed {
        op_t   op;
        word_t value;
        logic  ovf;
        logic  lt;
        logic  eq;
        logic  gt;
        logic  neg;
        logic  a_neg;
        logic  b_zero;
    } side_t;

    function automatic sat_t saturate(input wide_t v);
        sat_t r;
        if (v > SAT_HI) begin
            r.value = word_t'(SAT_HI);
            r.ovf   = 1'b1;
        end else if (v < SAT_LO) begin
            r.value = word_t'(SAT_LO);
            r.ovf   = 1'b1;
        end else begin
            r.value = word_t'(v);
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hdl/fq_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; instantiated by fixed_point_q24_8_alu.
`timescale 1ns / 1ps

module fq_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic [DEN_W-1:0] den_out
);

    // num_reg shifts the dividend out at the top and the quotient in at the bottom
    logic [NUM_W-1:0] num_reg  [NUM_W];
    logic [DEN_W-1:0] rem_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];
    logic [NUM_W-1:0] num_prev [NUM_W];
    logic [DEN_W-1:0] rem_prev [NUM_W];
    logic [DEN_W-1:0] den_prev [NUM_W];
    logic [NUM_W-1:0] num_next [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++) begin : g_stage
            if (g == 0) begin : g_first
                assign num_prev[g] = num;
                assign rem_prev[g] = '0;
                assign den_prev[g] = den;
            end else begin : g_rest
                assign num_prev[g] = num_reg[g-1];
                assign rem_prev[g] = rem_reg[g-1];
                assign den_prev[g] = den_reg[g-1];
            end
        end
    endgenerate

    always_comb begin
        logic [DEN_W:0] trial;
        logic           ge;
        for (int i = 0; i < NUM_W; i++) begin
            trial       = {rem_prev[i], num_prev[i][NUM_W-1]};
            ge          = (trial >= {1'b0, den_prev[i]});
            rem_next[i] = ge ? DEN_W'(trial - {1'b0, den_prev[i]}) : DEN_W'(trial);
            num_next[i] = {num_prev[i][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_W; i++) begin
                num_reg[i] <= num_next[i];
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_prev[i];
            end
        end
    end

    assign quo     = num_reg[NUM_W-1];
    assign rem     = rem_reg[NUM_W-1];
    assign den_out = den_reg[NUM_W-1];

endmodule

// ----- hdl/fixed_point_q24_8_alu.sv -----
// Signed Q24.8 fixed-point ALU, top level.
// Depends on fq_pkg and fq_div.
// Takes one word per clock unless the result side stalls, and returns one result
// word per input word, in order. Every operation has the same latency, set by
// the restoring divider, which resolves one quotient bit per stage over
// 32 + FRAC_BITS stages behind the input register; the output register follows.
// Back-pressure on the result side holds the whole pipeline, nothing is dropped.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu
    import fq_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_req_type,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic               m_a_less,
    output logic               m_a_equal,
    output logic               m_a_greater,
    output logic               m_overflow_flag,
    output logic               m_div_zero_flag
);

    localparam int NUM_W = WORD_W + FRAC_BITS;
    localparam int DEPTH = NUM_W;

    logic adv;

    // input register
    logic  in_valid_reg;
    op_t   in_op_reg;
    word_t in_a_reg;
    word_t in_b_reg;

    logic  v_reg    [1:DEPTH];
    side_t side_reg [1:DEPTH];
    logic [63:0] prod_reg;

    logic  out_valid_reg;
    sat_t  out_res_reg;
    logic  out_lt_reg, out_eq_reg, out_gt_reg, out_dz_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
        if (adv && s_valid) begin
            in_op_reg <= op_t'(s_req_type);
            in_a_reg  <= s_operand_a;
            in_b_reg  <= s_operand_b;
        end
    end

    // stage A: simple ops, compare flags, magnitudes
    wide_t       wa, wb, simple_wide;
    logic [31:0] mag_a, mag_b;
    sat_t        simple_sat;
    side_t       side_next;

    always_comb begin
        wa    = wide_t'(in_a_reg);
        wb    = wide_t'(in_b_reg);
        mag_a = in_a_reg[31] ? (~in_a_reg + 32'd1) : in_a_reg;
        mag_b = in_b_reg[31] ? (~in_b_reg + 32'd1) : in_b_reg;
        case (in_op_reg)
            OP_ADD:      simple_wide = wa + wb;
            OP_SUB:      simple_wide = wa - wb;
            OP_MIN:      simple_wide = (wa > wb) ? wb : wa;
            OP_MAX:      simple_wide = (wa < wb) ? wb : wa;
            OP_INC:      simple_wide = wa + wide_t'(1);
            OP_DEC:      simple_wide = wa - wide_t'(1);
            OP_FROM_INT: simple_wide = wa <<< FRAC_BITS;
            OP_TO_INT:   simple_wide = wa >>> FRAC_BITS;
            default:     simple_wide = '0;
        endcase
        simple_sat       = saturate(simple_wide);
        side_next.op     = in_op_reg;
        side_next.value  = simple_sat.value;
        side_next.ovf    = simple_sat.ovf;
        side_next.lt     = in_a_reg < in_b_reg;
        side_next.eq     = in_a_reg == in_b_reg;
        side_next.gt     = in_a_reg > in_b_reg;
        side_next.neg    = in_a_reg[31] ^ in_b_reg[31];
        side_next.a_neg  = in_a_reg[31];
        side_next.b_zero = (in_b_reg == '0);
    end

    logic [NUM_W-1:0] div_quo;
    logic [31:0]      div_rem, div_den;

    fq_div #(
        .NUM_W (NUM_W),
        .DEN_W (WORD_W)
    ) u_div (
        .aclk    (aclk),
        .en      (adv),
        .num     ({mag_a, FRAC_BITS'(0)}),
        .den     (mag_b),
        .quo     (div_quo),
        .rem     (div_rem),
        .den_out (div_den)
    );

    // stage C: round and saturate the product
    logic [63:0] prod_rnd;
    wide_t       mul_wide;
    sat_t        mul_sat;
    side_t       side_c_next;

    always_comb begin
        prod_rnd    = (prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        mul_wide    = wide_t'(prod_rnd);
        if (side_reg[1].neg) begin
            mul_wide = -mul_wide;
        end
        mul_sat     = saturate(mul_wide);
        side_c_next = side_reg[1];
        if (side_reg[1].op == OP_MUL) begin
            side_c_next.value = mul_sat.value;
            side_c_next.ovf   = mul_sat.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[1] <= in_valid_reg;
            for (int i = 2; i <= DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
        if (adv) begin
            prod_reg    <= 64'(mag_a) * 64'(mag_b);
            side_reg[1] <= side_next;
            side_reg[2] <= side_c_next;
            for (int i = 3; i <= DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // final stage: round the quotient and merge
    logic             round_up;
    wide_t            div_wide;
    sat_t             div_sat;
    sat_t             res_next;
    logic             dz_next;
    side_t            side_t_last;

    always_comb begin
        side_t_last = side_reg[DEPTH];
        round_up    = ({div_rem, 1'b0} >= {1'b0, div_den});
        div_wide    = wide_t'(div_quo) + wide_t'(round_up);
        if (side_t_last.neg) begin
            div_wide = -div_wide;
        end
        div_sat        = saturate(div_wide);
        res_next.value = side_t_last.value;
        res_next.ovf   = side_t_last.ovf;
        dz_next        = 1'b0;
        if (side_t_last.op == OP_DIV) begin
            if (side_t_last.b_zero) begin
                res_next.value = side_t_last.a_neg ? word_t'(SAT_LO) : word_t'(SAT_HI);
                res_next.ovf   = 1'b0;
                dz_next        = 1'b1;
            end else begin
                res_next = div_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v_reg[DEPTH];
        end
        if (adv && v_reg[DEPTH]) begin
            out_res_reg <= res_next;
            out_lt_reg  <= side_t_last.lt;
            out_eq_reg  <= side_t_last.eq;
            out_gt_reg  <= side_t_last.gt;
            out_dz_reg  <= dz_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_value  = out_res_reg.value;
    assign m_overflow_flag = out_res_reg.ovf;
    assign m_a_less        = out_lt_reg;
    assign m_a_equal       = out_eq_reg;
    assign m_a_greater     = out_gt_reg;
    assign m_div_zero_flag = out_dz_reg;

    a_cmp_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_a_less, m_a_equal, m_a_greater}))
        else $error("compare flags not one-hot");

    a_dz_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero_flag |-> !m_overflow_flag &&
        (m_result_value == word_t'(SAT_HI) || m_result_value == word_t'(SAT_LO)))
        else $error("divide by zero word not saturated");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow_flag |->
        (m_result_value == word_t'(SAT_HI) || m_result_value == word_t'(SAT_LO)))
        else $error("overflow word not at a rail");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_reg[DEPTH]) && $stable(in_valid_reg))
        else $error("pipeline moved during stall");

endmodule

// ----- bench/fq_alu_checker.sv -----
// Result checker for the Q24.8 fixed-point ALU: watches both channels,
// predicts each result word and compares it. Depends on fq_pkg.
`timescale 1ns / 1ps

module fq_alu_checker
    import fq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_req_type,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_result_value,
    input  logic               m_a_less,
    input  logic               m_a_equal,
    input  logic               m_a_greater,
    input  logic               m_overflow_flag,
    input  logic               m_div_zero_flag,
    output int                 fail_count,
    output int                 pending
);

    localparam int FRAC = 8;

    typedef struct packed {
        logic signed [31:0] value;
        logic lt;
        logic eq;
        logic gt;
        logic ovf;
        logic dz;
    } alu_res_t;

    alu_res_t expected_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [71:0] v,
                                                   inout logic ovf);
        if (v > 72'sh7FFFFFFF) begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end else if (v < -72'sh80000000) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic alu_res_t alu_predict(input logic [3:0] op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        alu_res_t r;
        logic signed [71:0] wa, wb, v;
        logic [71:0] ma, mb, q;
        logic neg;
        wa = a;
        wb = b;
        ma = wa < 0 ? -wa : wa;
        mb = wb < 0 ? -wb : wb;
        neg = (a < 0) != (b < 0);
        r = '0;
        v = 0;
        case (op)
            OP_ADD:      v = wa + wb;
            OP_SUB:      v = wa - wb;
            OP_MUL: begin
                q = (ma * mb + (72'd1 << (FRAC - 1))) >> FRAC;
                v = neg ? -$signed(q) : $signed(q);
            end
            OP_DIV: begin
                if (b == 0) r.dz = 1'b1;
                else begin
                    q = (2 * (ma << FRAC) + mb) / (2 * mb);
                    v = neg ? -$signed(q) : $signed(q);
                end
            end
            OP_MIN:      v = (wa > wb) ? wb : wa;
            OP_MAX:      v = (wa < wb) ? wb : wa;
            OP_INC:      v = wa + 1;
            OP_DEC:      v = wa - 1;
            OP_FROM_INT: v = wa <<< FRAC;
            OP_TO_INT:   v = wa >>> FRAC;
            default:     v = 0;
        endcase
        if (r.dz) r.value = (a >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        else r.value = clamp32(v, r.ovf);
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        alu_res_t got, exp_r;
        if (!aresetn) begin
            fail_count <= 0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(alu_predict(s_req_type, s_operand_a, s_operand_b));
            if (m_valid && m_ready) begin
                got = {m_result_value, m_a_less, m_a_equal, m_a_greater,
                       m_overflow_flag, m_div_zero_flag};
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word: value %h", m_result_value);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        if (fail_count < 10)
                            $display("mismatch: exp val %h lt%b eq%b gt%b ov%b dz%b, got val %h lt%b eq%b gt%b ov%b dz%b",
                                     exp_r.value, exp_r.lt, exp_r.eq, exp_r.gt,
                                     exp_r.ovf, exp_r.dz, got.value, got.lt,
                                     got.eq, got.gt, got.ovf, got.dz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/fixed_point_q24_8_alu_tb.sv -----
// Testbench top for the Q24.8 fixed-point ALU: directed and random stimulus
// with random idling. Depends on fq_pkg, fixed_point_q24_8_alu, fq_alu_checker.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;
    import fq_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_req_type = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result_value;
    logic               m_a_less, m_a_equal, m_a_greater;
    logic               m_overflow_flag, m_div_zero_flag;
    int                 fail_count;
    int                 pending;
    bit                 calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fixed_point_q24_8_alu DUT (.*);

    fq_alu_checker u_checker (.*);

    // result side stalls in bursts until the calm tail of the run
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // valid stays up between back-to-back words; the caller drops it when done
    task automatic send_word(input logic [3:0] op, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 1023)) - 512;
            2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            3: return 32'sh7FFFFFFF - $urandom_range(0, 3);
            4: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom) >>> $urandom_range(0, 30);
        endcase
    endfunction

    initial begin
        logic signed [31:0] a;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes, every operation code, two unused codes, divide by zero, rounding halves
        send_word(OP_ADD, 32'sh7FFFFFFF, 32'sh1);
        send_word(OP_ADD, 32'sh80000000, -32'sh1);
        send_word(OP_SUB, 32'sh80000000, 32'sh1);
        send_word(OP_SUB, 32'sh7FFFFFFF, 32'sh80000000);
        send_word(OP_MUL, 32'sh80000000, 32'sh80000000);
        send_word(OP_MUL, 32'sh180, 32'sh80);
        send_word(OP_MUL, -32'sh180, 32'sh80);
        send_word(OP_MUL, 32'sh1, 32'sh80);
        send_word(OP_DIV, 32'sh100, 32'sh0);
        send_word(OP_DIV, 32'sh0, 32'sh0);
        send_word(OP_DIV, -32'sh1, 32'sh0);
        send_word(OP_DIV, 32'sh80000000, 32'sh1);
        send_word(OP_DIV, 32'sh1, 32'sh200);
        send_word(OP_DIV, -32'sh1, 32'sh200);
        send_word(OP_MIN, 32'sh5, -32'sh5);
        send_word(OP_MAX, 32'sh5, -32'sh5);
        send_word(OP_INC, 32'sh7FFFFFFF, 32'sh0);
        send_word(OP_DEC, 32'sh80000000, 32'sh0);
        send_word(OP_FROM_INT, 32'sh00800000, 32'sh0);
        send_word(OP_FROM_INT, -32'sh00800001, 32'sh0);
        send_word(OP_TO_INT, -32'sh1, 32'sh0);
        send_word(OP_TO_INT, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_word(4'd10, 32'sh3, 32'sh3);
        send_word(4'd15, -32'sh1, 32'sh2);
        s_valid <= 1'b0;
        // hold off until the pipeline has drained
        while (pending != 0) @(negedge aclk);
        for (int i = 0; i < 950; i++) begin
            if (i == 800) calm = 1'b1;
            a = rand_operand();
            send_word($urandom_range(0, 15) < 13 ? 4'($urandom_range(0, 9))
                                               : 4'($urandom_range(10, 15)),
                      a, ($urandom_range(0, 9) == 0) ? a
                         : ($urandom_range(0, 12) == 0 ? 32'sh0 : rand_operand()));
        end
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0)
            $display("fixed_point_q24_8_alu_tb OK");
        else
            $display("fixed_point_q24_8_alu_tb NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("fixed_point_q24_8_alu_tb NOT OK");
        $finish;
    end

endmodule

// ----- fixed_point_q24_8_alu.f -----
hdl/fq_pkg.sv
hdl/fq_div.sv
hdl/fixed_point_q24_8_alu.sv
bench/fq_alu_checker.sv
bench/fixed_point_q24_8_alu_tb.sv
